FILE: rtl/core/sdsr_pkg.sv
// ----------------------------------------------------------------------------
// sdsr_pkg
// Shared widths, codes and bundles of the SD card SPI block read sequencer.
// ----------------------------------------------------------------------------
package sdsr_pkg;

   localparam int BLOCK_BYTES  = 512;
   localparam int BYTE_CNT_W   = 10;
   localparam int POLL_W       = 24;
   localparam int BLOCKS_W     = 9;
   localparam int SECTOR_W     = 23;
   localparam int COUNT_W      = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 24;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_READY_POLL_LIMIT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOKEN_POLL_LIMIT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESPONSE_POLL_LIMIT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_CRC         = 2'd3;

   // item function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_BYTE  = 1'b1;

   // transfer status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_READY = 2'd1;
   localparam logic [1:0] STATUS_REJECTED  = 2'd2;
   localparam logic [1:0] STATUS_TIMEOUT   = 2'd3;

   // SD command indexes
   localparam logic [5:0] CMD_READ_SINGLE = 6'd17;
   localparam logic [5:0] CMD_READ_MULTI  = 6'd18;
   localparam logic [5:0] CMD_STOP        = 6'd12;

   localparam logic [7:0] BYTE_IDLE    = 8'hFF;
   localparam logic [7:0] TOKEN_START  = 8'hFE;
   localparam logic [7:0] CMD_PREFIX   = 8'h40;

   typedef struct packed {
      logic                func;
      logic [SECTOR_W-1:0] sector;
      logic [COUNT_W-1:0]  block_count;
      logic [7:0]          rx_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       select_high;
      logic [7:0] data_byte;
      logic       data_valid;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] response;
   } result_type;

   typedef struct packed {
      logic [23:0] ready_poll_limit;
      logic [15:0] token_poll_limit;
      logic [7:0]  response_poll_limit;
      logic [7:0]  command_crc;
   } cfg_type;

endpackage

FILE: rtl/core/sdsr_req_if.sv
// ----------------------------------------------------------------------------
// sdsr_req_if
// Request channel: start items and bytes received from the card.
// ----------------------------------------------------------------------------
interface sdsr_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [sdsr_pkg::SECTOR_W-1:0] sector;
   logic [sdsr_pkg::COUNT_W-1:0]  block_count;
   logic [7:0]                    rx_byte;

   modport source (output valid, func, sector, block_count, rx_byte, input ready);
   modport sink (input valid, func, sector, block_count, rx_byte, output ready);
endinterface

FILE: rtl/core/sdsr_rsp_if.sv
// ----------------------------------------------------------------------------
// sdsr_rsp_if
// Response channel: next byte to send, select level, data and status.
// ----------------------------------------------------------------------------
interface sdsr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       select_high;
   logic [7:0] data_byte;
   logic       data_valid;
   logic       done_res;
   logic [1:0] status;
   logic [7:0] response;

   modport source (output valid, tx_byte, select_high, data_byte, data_valid,
                   done_res, status, response, input ready);
   modport sink (input valid, tx_byte, select_high, data_byte, data_valid,
                 done_res, status, response, output ready);
endinterface

FILE: rtl/core/sdsr_csr.sv
// ----------------------------------------------------------------------------
// sdsr_csr
// Configuration registers: poll limits and command CRC byte.
// ----------------------------------------------------------------------------
module sdsr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sdsr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sdsr_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output sdsr_pkg::cfg_type                   cfg
);

   sdsr_pkg::cfg_type cfg_ff;
   sdsr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            sdsr_pkg::CSR_READY_POLL_LIMIT:    cfg_in.ready_poll_limit = csr_write_data;
            sdsr_pkg::CSR_TOKEN_POLL_LIMIT:    cfg_in.token_poll_limit = csr_write_data[15:0];
            sdsr_pkg::CSR_RESPONSE_POLL_LIMIT: cfg_in.response_poll_limit = csr_write_data[7:0];
            sdsr_pkg::CSR_COMMAND_CRC:         cfg_in.command_crc = csr_write_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ready_poll_limit    <= 24'hFFFFFF;
         cfg_ff.token_poll_limit    <= 16'hFFFF;
         cfg_ff.response_poll_limit <= 8'd32;
         cfg_ff.command_crc         <= 8'h01;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/sdsr_engine.sv
// ----------------------------------------------------------------------------
// sdsr_engine
// Sequencer state and the single-pass decision of the next SPI exchange.
// ----------------------------------------------------------------------------
module sdsr_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  sdsr_pkg::item_type     item,
   input  sdsr_pkg::cfg_type      cfg,
   output sdsr_pkg::result_type   result
);

   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_DESEL   = 4'd1;
   localparam logic [3:0] PH_READY   = 4'd2;
   localparam logic [3:0] PH_SELFAIL = 4'd3;
   localparam logic [3:0] PH_CMD     = 4'd4;
   localparam logic [3:0] PH_STUFF   = 4'd5;
   localparam logic [3:0] PH_RESP    = 4'd6;
   localparam logic [3:0] PH_TOKEN   = 4'd7;
   localparam logic [3:0] PH_DATA    = 4'd8;
   localparam logic [3:0] PH_CRC     = 4'd9;

   localparam logic [sdsr_pkg::BYTE_CNT_W:0] LAST_DATA =
      (sdsr_pkg::BYTE_CNT_W+1)'(sdsr_pkg::BLOCK_BYTES);
   localparam logic [sdsr_pkg::BYTE_CNT_W-1:0] CMD_LAST = 10'd5;

   logic [3:0]                        phase_ff, phase_in;
   logic [sdsr_pkg::BYTE_CNT_W-1:0]   byte_cnt_ff, byte_cnt_in;
   logic [sdsr_pkg::POLL_W-1:0]       poll_cnt_ff, poll_cnt_in;
   logic [sdsr_pkg::BLOCKS_W-1:0]     blocks_left_ff, blocks_left_in;
   logic [31:0]                       byte_addr_ff, byte_addr_in;
   logic [5:0]                        cmd_ff, cmd_in;
   logic [7:0]                        last_resp_ff, last_resp_in;
   logic                              multi_ff, multi_in;
   logic [1:0]                        outcome_ff, outcome_in;

   logic [sdsr_pkg::POLL_W-1:0]       poll_inc;
   logic [sdsr_pkg::BYTE_CNT_W:0]     byte_cnt_inc;
   logic [sdsr_pkg::BLOCKS_W-1:0]     blocks_dec;
   logic [sdsr_pkg::BLOCKS_W-1:0]     blocks_start;
   logic                              done;

   // byte k of the six-byte command frame
   function automatic logic [7:0] cmd_byte(input logic [2:0] k, input logic [5:0] cmd,
                                           input logic [31:0] addr, input logic [7:0] crc);
      logic [31:0] arg;
      logic [7:0]  b;
      arg = (cmd == sdsr_pkg::CMD_STOP) ? 32'd0 : addr;
      case (k)
         3'd0:    b = {2'b00, cmd} | sdsr_pkg::CMD_PREFIX;
         3'd1:    b = arg[31:24];
         3'd2:    b = arg[23:16];
         3'd3:    b = arg[15:8];
         3'd4:    b = arg[7:0];
         default: b = crc;
      endcase
      return b;
   endfunction

   assign poll_inc     = poll_cnt_ff + 1'b1;
   assign byte_cnt_inc = {1'b0, byte_cnt_ff} + 1'b1;
   assign blocks_dec   = (blocks_left_ff == '0) ? '0 : blocks_left_ff - 1'b1;
   assign blocks_start = (item.block_count == '0) ?
                         sdsr_pkg::BLOCKS_W'(256) : {1'b0, item.block_count};

   always_comb begin
      phase_in       = phase_ff;
      byte_cnt_in    = byte_cnt_ff;
      poll_cnt_in    = poll_cnt_ff;
      blocks_left_in = blocks_left_ff;
      byte_addr_in   = byte_addr_ff;
      cmd_in         = cmd_ff;
      last_resp_in   = last_resp_ff;
      multi_in       = multi_ff;
      outcome_in     = outcome_ff;
      done           = 1'b0;

      result             = '0;
      result.tx_byte     = sdsr_pkg::BYTE_IDLE;
      result.select_high = 1'b1;

      if (item.func == sdsr_pkg::FUNC_START) begin
         // start: latch the transfer and open the read command
         byte_addr_in       = {item.sector, 9'd0};
         blocks_left_in     = blocks_start;
         multi_in           = (blocks_start != sdsr_pkg::BLOCKS_W'(1));
         last_resp_in       = 8'hFF;
         outcome_in         = sdsr_pkg::STATUS_OK;
         byte_cnt_in        = '0;
         poll_cnt_in        = '0;
         cmd_in             = (blocks_start != sdsr_pkg::BLOCKS_W'(1)) ?
                              sdsr_pkg::CMD_READ_MULTI : sdsr_pkg::CMD_READ_SINGLE;
         phase_in           = PH_DESEL;
      end else begin
         case (phase_ff)
            PH_DESEL: begin
               phase_in           = PH_READY;
               poll_cnt_in        = 24'd1;
               result.select_high = 1'b0;
            end
            PH_READY: begin
               if (item.rx_byte == sdsr_pkg::BYTE_IDLE) begin
                  phase_in           = PH_CMD;
                  byte_cnt_in        = '0;
                  result.tx_byte     = cmd_byte(3'd0, cmd_ff, byte_addr_ff, cfg.command_crc);
                  result.select_high = 1'b0;
               end else if (poll_cnt_ff >= cfg.ready_poll_limit) begin
                  if (cmd_ff != sdsr_pkg::CMD_STOP) begin
                     outcome_in = sdsr_pkg::STATUS_NOT_READY;
                  end
                  phase_in = PH_SELFAIL;
               end else begin
                  poll_cnt_in        = poll_inc;
                  result.select_high = 1'b0;
               end
            end
            PH_SELFAIL: begin
               done = 1'b1;
            end
            PH_CMD: begin
               result.select_high = 1'b0;
               if (byte_cnt_ff < CMD_LAST) begin
                  byte_cnt_in    = byte_cnt_inc[sdsr_pkg::BYTE_CNT_W-1:0];
                  result.tx_byte = cmd_byte(byte_cnt_inc[2:0], cmd_ff, byte_addr_ff,
                                            cfg.command_crc);
               end else if (cmd_ff == sdsr_pkg::CMD_STOP) begin
                  phase_in = PH_STUFF;
               end else begin
                  phase_in    = PH_RESP;
                  poll_cnt_in = 24'd1;
               end
            end
            PH_STUFF: begin
               phase_in           = PH_RESP;
               poll_cnt_in        = 24'd1;
               result.select_high = 1'b0;
            end
            PH_RESP: begin
               if (item.rx_byte[7] && (poll_cnt_ff < {16'd0, cfg.response_poll_limit})) begin
                  poll_cnt_in        = poll_inc;
                  result.select_high = 1'b0;
               end else begin
                  last_resp_in = item.rx_byte;
                  if (cmd_ff == sdsr_pkg::CMD_STOP) begin
                     done = 1'b1;
                  end else if (item.rx_byte == 8'd0) begin
                     phase_in           = PH_TOKEN;
                     poll_cnt_in        = 24'd1;
                     result.select_high = 1'b0;
                  end else begin
                     outcome_in = sdsr_pkg::STATUS_REJECTED;
                     done       = 1'b1;
                  end
               end
            end
            PH_TOKEN: begin
               if (item.rx_byte == sdsr_pkg::TOKEN_START) begin
                  phase_in           = PH_DATA;
                  byte_cnt_in        = '0;
                  result.select_high = 1'b0;
               end else if (poll_cnt_ff >= {8'd0, cfg.token_poll_limit}) begin
                  outcome_in = sdsr_pkg::STATUS_TIMEOUT;
                  if (multi_ff) begin
                     cmd_in   = sdsr_pkg::CMD_STOP;
                     phase_in = PH_DESEL;
                  end else begin
                     done = 1'b1;
                  end
               end else begin
                  poll_cnt_in        = poll_inc;
                  result.select_high = 1'b0;
               end
            end
            PH_DATA: begin
               result.data_byte   = item.rx_byte;
               result.data_valid  = 1'b1;
               result.select_high = 1'b0;
               if (byte_cnt_inc < LAST_DATA) begin
                  byte_cnt_in = byte_cnt_inc[sdsr_pkg::BYTE_CNT_W-1:0];
               end else begin
                  phase_in    = PH_CRC;
                  byte_cnt_in = '0;
               end
            end
            PH_CRC: begin
               if (byte_cnt_ff == '0) begin
                  byte_cnt_in        = 10'd1;
                  result.select_high = 1'b0;
               end else begin
                  blocks_left_in = blocks_dec;
                  if (!multi_ff) begin
                     done = 1'b1;
                  end else if (blocks_dec != '0) begin
                     phase_in           = PH_TOKEN;
                     poll_cnt_in        = 24'd1;
                     result.select_high = 1'b0;
                  end else begin
                     cmd_in   = sdsr_pkg::CMD_STOP;
                     phase_in = PH_DESEL;
                  end
               end
            end
            default: begin
               // idle: answer with a deselected filler byte
               phase_in = phase_ff;
            end
         endcase
      end

      if (done) begin
         phase_in        = PH_IDLE;
         result.done_res = 1'b1;
         result.status   = outcome_in;
      end
      result.response = last_resp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         byte_cnt_ff    <= '0;
         poll_cnt_ff    <= '0;
         blocks_left_ff <= '0;
         byte_addr_ff   <= '0;
         cmd_ff         <= '0;
         last_resp_ff   <= 8'hFF;
         multi_ff       <= 1'b0;
         outcome_ff     <= sdsr_pkg::STATUS_OK;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         byte_cnt_ff    <= byte_cnt_in;
         poll_cnt_ff    <= poll_cnt_in;
         blocks_left_ff <= blocks_left_in;
         byte_addr_ff   <= byte_addr_in;
         cmd_ff         <= cmd_in;
         last_resp_ff   <= last_resp_in;
         multi_ff       <= multi_in;
         outcome_ff     <= outcome_in;
      end
   end

`ifndef SYNTHESIS
   a_done_deselects: assert property (@(posedge clock) disable iff (reset)
      step_en && result.done_res |-> result.select_high)
      else $error("transfer end without deselect");

   a_data_selected: assert property (@(posedge clock) disable iff (reset)
      step_en && result.data_valid |-> !result.select_high && !result.done_res)
      else $error("data byte outside a selected exchange");

   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      step_en && !result.done_res |-> result.status == sdsr_pkg::STATUS_OK)
      else $error("status reported before the transfer ended");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && result.done_res |=> phase_ff == PH_IDLE)
      else $error("sequencer busy after transfer end");

   a_crc_after_data: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CRC |-> $past(phase_ff) == PH_DATA || $past(phase_ff) == PH_CRC)
      else $error("CRC phase entered without data");
`endif

endmodule

FILE: rtl/core/sd_spi_block_read_sequencer.sv
// ----------------------------------------------------------------------------
// sd_spi_block_read_sequencer
// Host-side SD card SPI-mode block read sequencer, one SPI byte per beat.
// ----------------------------------------------------------------------------
// A start beat (func 0) loads the first sector and block count (0 means 256)
// and launches a CMD17 single-block or CMD18 multi-block read; every later
// beat (func 1) carries the byte the card returned in the last exchange.
// Each request beat produces exactly one response beat with the next byte to
// send, the chip-select level, any sector data byte and, on the final
// deselect, done_res with the status. The block takes one request beat per
// clock unless the response side stalls: a request register feeds the
// single-pass decision logic, whose result lands in a response register.
// req ready follows rsp ready combinationally through the two register
// stages; a stalled response holds both stages. Poll limits and the command
// CRC byte are for the user to write through the csr port while idle; the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
module sd_spi_block_read_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   sdsr_req_if.sink                          req_chan,
   sdsr_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [sdsr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sdsr_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   sdsr_pkg::cfg_type    cfg;
   sdsr_pkg::item_type   item_ff;
   logic                 item_valid_ff;
   sdsr_pkg::result_type step_result;
   sdsr_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 step_en;
   logic                 req_fire;

   // advance the request stage when the response register is free or draining
   assign step_en  = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || step_en;
   assign req_fire = req_chan.valid && req_chan.ready;

   sdsr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   sdsr_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // request register: payload loads on accept, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.func        <= req_chan.func;
         item_ff.sector      <= req_chan.sector;
         item_ff.block_count <= req_chan.block_count;
         item_ff.rx_byte     <= req_chan.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_valid_ff <= req_chan.valid;
      end
   end

   // response register: hold while the sink stalls
   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tx_byte     = rsp_ff.tx_byte;
   assign rsp_chan.select_high = rsp_ff.select_high;
   assign rsp_chan.data_byte   = rsp_ff.data_byte;
   assign rsp_chan.data_valid  = rsp_ff.data_valid;
   assign rsp_chan.done_res    = rsp_ff.done_res;
   assign rsp_chan.status      = rsp_ff.status;
   assign rsp_chan.response    = rsp_ff.response;

`ifndef SYNTHESIS
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff)
      else $error("pending response lost");

   a_item_flows: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("processed beat produced no response");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !step_en |=> item_valid_ff && $stable(item_ff))
      else $error("stalled request changed");
`endif

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SD card SPI-mode block read sequencer.
// ----------------------------------------------------------------------------
// Acts as the card: every beat on req carries either a read start or the byte
// the card answered in the last exchange. A behavioral copy of the sequencer
// runs in a scoreboard class, predicts each rsp beat at the moment its req
// beat is accepted, and compares the DUT beats in order. The card answers are
// chosen from the predicted sequencer phase so that most transfers get deep
// (ready, R1, token, 512 data bytes, CRC, CMD12), while planned faults drive
// every poll limit and error ending. The run walks several register settings,
// including the extremes and zero poll limits.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdsr_pkg::*;

   localparam int          WATCHDOG_LIMIT   = 3000;
   localparam int          LONG_HOLD_CYCLES = 400;
   localparam int          DRAIN_SETTLE     = 8;
   localparam int          SMALL_LIMIT      = 64;
   localparam logic [7:0]  R1_READY         = 8'h00;
   localparam logic [7:0]  R1_ERROR_BIT     = 8'h80;
   localparam logic [5:0]  CMD_NONE         = 6'd0;

   typedef enum logic [4:0] {
      SEQ_IDLE, SEQ_DESELECT, SEQ_READY_POLL, SEQ_SELECT_FAIL, SEQ_COMMAND,
      SEQ_STUFF, SEQ_RESPONSE, SEQ_TOKEN, SEQ_DATA, SEQ_CRC
   } seq_phase_e;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_RANDOM, STALL_ONE_IN_FOUR, STALL_SPARSE
   } stall_mode_e;

   // -------------------------------------------------------------------------
   // Scoreboard: behavioral sequencer plus the queue of predicted rsp beats
   // -------------------------------------------------------------------------
   class block_read_scoreboard;
      cfg_type      cfg;
      seq_phase_e   phase;
      logic [9:0]   byte_count;
      logic [23:0]  poll_count;
      logic [8:0]   blocks_left;
      logic [31:0]  byte_address;
      logic [5:0]   command_index;
      logic [7:0]   last_response;
      logic         multi_block;
      logic [1:0]   outcome;
      result_type   next_beat;
      result_type   expected_beats[$];
      int           mismatches;
      int           transfers;
      int           data_beats;
      int           checked;
      int           endings[4];

      function new();
         cfg.ready_poll_limit    = 24'hFFFFFF;
         cfg.token_poll_limit    = 16'hFFFF;
         cfg.response_poll_limit = 8'd32;
         cfg.command_crc         = 8'h01;
         phase         = SEQ_IDLE;
         byte_count    = '0;
         poll_count    = '0;
         blocks_left   = '0;
         byte_address  = '0;
         command_index = '0;
         last_response = BYTE_IDLE;
         multi_block   = 1'b0;
         outcome       = STATUS_OK;
         mismatches    = 0;
         transfers     = 0;
         data_beats    = 0;
         checked       = 0;
         foreach (endings[i]) endings[i] = 0;
      endfunction

      function void report_mismatch(string msg);
         mismatches++;
         $display("%0t ns  mismatch: %s", $time, msg);
      endfunction

      function void configure(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_READY_POLL_LIMIT:    cfg.ready_poll_limit    = value;
            CSR_TOKEN_POLL_LIMIT:    cfg.token_poll_limit    = value[15:0];
            CSR_RESPONSE_POLL_LIMIT: cfg.response_poll_limit = value[7:0];
            default:                 cfg.command_crc         = value[7:0];
         endcase
      endfunction

      function void drive_byte(logic [7:0] tx, logic deselect);
         next_beat.tx_byte     = tx;
         next_beat.select_high = deselect;
      endfunction

      function void start_command(logic [5:0] cmd);
         command_index = cmd;
         phase         = SEQ_DESELECT;
         drive_byte(BYTE_IDLE, 1'b1);
      endfunction

      function void close_transfer();
         phase = SEQ_IDLE;
         drive_byte(BYTE_IDLE, 1'b1);
         next_beat.done_res = 1'b1;
         next_beat.status   = outcome;
      endfunction

      function void enter_token_poll();
         phase      = SEQ_TOKEN;
         poll_count = 24'd1;
         drive_byte(BYTE_IDLE, 1'b0);
      endfunction

      // k = 0 opcode, 1..4 argument MSB first, 5 CRC
      function logic [7:0] command_byte(int k);
         logic [31:0] arg;
         arg = (command_index == CMD_STOP) ? 32'd0 : byte_address;
         if (k == 0) return {2'b00, command_index} | CMD_PREFIX;
         if (k >= 5) return cfg.command_crc;
         return 8'(arg >> (8 * (4 - k)));
      endfunction

      function void note_item(item_type it);
         logic [7:0] rx;
         rx        = it.rx_byte;
         next_beat = '0;
         drive_byte(BYTE_IDLE, 1'b1);
         if (it.func == FUNC_START) begin
            transfers++;
            byte_address  = {it.sector, 9'd0};
            blocks_left   = (it.block_count == '0) ? 9'd256 : {1'b0, it.block_count};
            multi_block   = (blocks_left != 9'd1);
            last_response = BYTE_IDLE;
            outcome       = STATUS_OK;
            byte_count    = '0;
            poll_count    = '0;
            start_command(multi_block ? CMD_READ_MULTI : CMD_READ_SINGLE);
         end else begin
            case (phase)
               SEQ_DESELECT: begin
                  phase      = SEQ_READY_POLL;
                  poll_count = 24'd1;
                  drive_byte(BYTE_IDLE, 1'b0);
               end
               SEQ_READY_POLL: begin
                  if (rx == BYTE_IDLE) begin
                     phase      = SEQ_COMMAND;
                     byte_count = '0;
                     drive_byte(command_byte(0), 1'b0);
                  end else if (poll_count >= cfg.ready_poll_limit) begin
                     // a stop command that fails keeps the data phase status
                     if (command_index != CMD_STOP) outcome = STATUS_NOT_READY;
                     phase = SEQ_SELECT_FAIL;
                     drive_byte(BYTE_IDLE, 1'b1);
                  end else begin
                     poll_count = poll_count + 24'd1;
                     drive_byte(BYTE_IDLE, 1'b0);
                  end
               end
               SEQ_SELECT_FAIL: close_transfer();
               SEQ_COMMAND: begin
                  if (byte_count < 10'd5) begin
                     byte_count = byte_count + 10'd1;
                     drive_byte(command_byte(int'(byte_count)), 1'b0);
                  end else if (command_index == CMD_STOP) begin
                     phase = SEQ_STUFF;
                     drive_byte(BYTE_IDLE, 1'b0);
                  end else begin
                     phase      = SEQ_RESPONSE;
                     poll_count = 24'd1;
                     drive_byte(BYTE_IDLE, 1'b0);
                  end
               end
               SEQ_STUFF: begin
                  phase      = SEQ_RESPONSE;
                  poll_count = 24'd1;
                  drive_byte(BYTE_IDLE, 1'b0);
               end
               SEQ_RESPONSE: begin
                  if (rx[7] && poll_count < {16'd0, cfg.response_poll_limit}) begin
                     poll_count = poll_count + 24'd1;
                     drive_byte(BYTE_IDLE, 1'b0);
                  end else begin
                     last_response = rx;
                     if (command_index == CMD_STOP) close_transfer();
                     else if (rx == R1_READY) enter_token_poll();
                     else begin
                        outcome = STATUS_REJECTED;
                        close_transfer();
                     end
                  end
               end
               SEQ_TOKEN: begin
                  if (rx == TOKEN_START) begin
                     phase      = SEQ_DATA;
                     byte_count = '0;
                     drive_byte(BYTE_IDLE, 1'b0);
                  end else if (poll_count >= {8'd0, cfg.token_poll_limit}) begin
                     outcome = STATUS_TIMEOUT;
                     if (multi_block) start_command(CMD_STOP);
                     else close_transfer();
                  end else begin
                     poll_count = poll_count + 24'd1;
                     drive_byte(BYTE_IDLE, 1'b0);
                  end
               end
               SEQ_DATA: begin
                  next_beat.data_byte  = rx;
                  next_beat.data_valid = 1'b1;
                  if (int'(byte_count) + 1 < BLOCK_BYTES) byte_count = byte_count + 10'd1;
                  else begin
                     phase      = SEQ_CRC;
                     byte_count = '0;
                  end
                  drive_byte(BYTE_IDLE, 1'b0);
               end
               SEQ_CRC: begin
                  if (byte_count == '0) begin
                     byte_count = 10'd1;
                     drive_byte(BYTE_IDLE, 1'b0);
                  end else begin
                     if (blocks_left != '0) blocks_left = blocks_left - 9'd1;
                     if (!multi_block) close_transfer();
                     else if (blocks_left != '0) enter_token_poll();
                     else start_command(CMD_STOP);
                  end
               end
               default: ;
            endcase
         end
         next_beat.response = last_response;
         expected_beats.push_back(next_beat);
      endfunction

      function void check_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report_mismatch($sformatf("beat %0d %s got %0h expected %0h",
                                      checked, name, got, want));
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_beats.size() == 0) begin
            report_mismatch("rsp beat arrived with nothing predicted");
            return;
         end
         want = expected_beats.pop_front();
         check_field("tx_byte", got.tx_byte, want.tx_byte);
         check_field("select_high", 8'(got.select_high), 8'(want.select_high));
         check_field("data_byte", got.data_byte, want.data_byte);
         check_field("data_valid", 8'(got.data_valid), 8'(want.data_valid));
         check_field("done_res", 8'(got.done_res), 8'(want.done_res));
         check_field("status", 8'(got.status), 8'(want.status));
         check_field("response", got.response, want.response);
         if (want.data_valid) data_beats++;
         if (want.done_res) endings[want.status]++;
         checked++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, DUT
   // -------------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   sdsr_req_if req_bus ();
   sdsr_rsp_if rsp_bus ();

   sd_spi_block_read_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   block_read_scoreboard sb;

   // sender and card-emulation state
   int         burst_left;
   int         transfer_items;
   bit         hold_request;
   bit         hold_done;
   int         plan_blocks;
   logic [5:0] plan_ready_stuck;
   logic [5:0] plan_resp_reject;
   logic [5:0] plan_resp_stuck;
   int         plan_token_from;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor: note accepted req beats, check accepted rsp beats. Both sample
   // at the rising edge, before the DUT registers move.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      item_type   it;
      result_type rs;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            it.func        = req_bus.func;
            it.sector      = req_bus.sector;
            it.block_count = req_bus.block_count;
            it.rx_byte     = req_bus.rx_byte;
            sb.note_item(it);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rs.tx_byte     = rsp_bus.tx_byte;
            rs.select_high = rsp_bus.select_high;
            rs.data_byte   = rsp_bus.data_byte;
            rs.data_valid  = rsp_bus.data_valid;
            rs.done_res    = rsp_bus.done_res;
            rs.status      = rsp_bus.status;
            rs.response    = rsp_bus.response;
            sb.check_result(rs);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run when no beat moves on either side for too long
   // -------------------------------------------------------------------------
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: rsp ready follows a random stall pattern that is picked anew
   // when its run ends; once, on request, hold it low long enough to back up req.
   // -------------------------------------------------------------------------
   initial begin
      stall_mode_e mode;
      int          mode_left;
      int          tick;
      rsp_bus.ready = 1'b0;
      mode          = STALL_NONE;
      mode_left     = 0;
      tick          = 0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_bus.ready = 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_e'($urandom_range(0, 3));
               mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            tick++;
            case (mode)
               STALL_NONE:        rsp_bus.ready = 1'b1;
               STALL_RANDOM:      rsp_bus.ready = 1'($urandom_range(0, 1));
               STALL_ONE_IN_FOUR: rsp_bus.ready = (tick % 4 == 0);
               default:           rsp_bus.ready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driver tasks. Everything changes at the falling edge.
   // -------------------------------------------------------------------------

   // Offer one req beat and hold it until accepted, then drop valid unless the
   // next call raises it again at the same falling edge. Bursts of random
   // length are separated by random gaps with valid low.
   task automatic send_beat(input item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
      end
      req_bus.func        = it.func;
      req_bus.sector      = it.sector;
      req_bus.block_count = it.block_count;
      req_bus.rx_byte     = it.rx_byte;
      req_bus.valid       = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic send_start(input logic [SECTOR_W-1:0] sector, input logic [COUNT_W-1:0] count);
      item_type it;
      it.func        = FUNC_START;
      it.sector      = sector;
      it.block_count = count;
      it.rx_byte     = 8'($urandom);
      send_beat(it);
   endtask

   task automatic send_card_byte(input logic [7:0] rx);
      item_type it;
      it.func        = FUNC_BYTE;
      it.sector      = SECTOR_W'($urandom);
      it.block_count = COUNT_W'($urandom);
      it.rx_byte     = rx;
      send_beat(it);
   endtask

   // Wait until every predicted beat is back, then let the pipeline settle.
   task automatic wait_for_drain();
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = value;
      @(posedge clock);
      sb.configure(index, value);
      @(negedge clock);
   endtask

   // Program all four registers back to back; only called while drained.
   task automatic program_registers(input logic [23:0] ready_limit, input logic [15:0] token_limit,
                                    input logic [7:0] resp_limit, input logic [7:0] crc);
      write_register(CSR_READY_POLL_LIMIT, ready_limit);
      write_register(CSR_TOKEN_POLL_LIMIT, {8'd0, token_limit});
      write_register(CSR_RESPONSE_POLL_LIMIT, {16'd0, resp_limit});
      write_register(CSR_COMMAND_CRC, {16'd0, crc});
      csr_write_enable = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Card emulation
   // -------------------------------------------------------------------------

   // Pick the faults of the transfer that a start launches. A ready or token poll fault
   // is only planned where its poll limit is small enough to run out quickly.
   // Multi-block reads of many blocks are always cut short by a fault.
   task automatic choose_plan(input logic [COUNT_W-1:0] count, input bit clean);
      logic [5:0] first_cmd;
      bit         small_ready;
      bit         small_token;
      int         pick;
      plan_blocks      = (count == '0) ? 256 : int'(count);
      first_cmd        = (plan_blocks != 1) ? CMD_READ_MULTI : CMD_READ_SINGLE;
      plan_ready_stuck = CMD_NONE;
      plan_resp_reject = CMD_NONE;
      plan_resp_stuck  = CMD_NONE;
      plan_token_from  = -1;
      if (!clean) begin
         small_ready = (sb.cfg.ready_poll_limit <= SMALL_LIMIT);
         small_token = (sb.cfg.token_poll_limit <= SMALL_LIMIT);
         pick        = $urandom_range(0, 9);
         if (pick < 2 && small_ready)
            plan_ready_stuck = (first_cmd == CMD_READ_MULTI && $urandom_range(0, 1))
                               ? CMD_STOP : first_cmd;
         else if (pick == 2) plan_resp_reject = first_cmd;
         else if (pick == 3) plan_resp_stuck = first_cmd;
         else if (pick < 6 && small_token) plan_token_from = 0;
         if (first_cmd == CMD_READ_MULTI && plan_ready_stuck != first_cmd &&
             plan_resp_reject == CMD_NONE && plan_resp_stuck == CMD_NONE &&
             plan_token_from < 0) begin
            if (small_token) plan_token_from = $urandom_range(0, 1);
            else plan_resp_reject = first_cmd;
         end
      end
   endtask

   // Answer from the card, chosen from the sequencer phase the scoreboard
   // predicts for the next exchange.
   function automatic logic [7:0] pick_card_byte();
      logic [7:0] rx;
      int         blocks_done;
      rx          = 8'($urandom);
      blocks_done = plan_blocks - int'(sb.blocks_left);
      case (sb.phase)
         SEQ_READY_POLL: begin
            if (sb.command_index == plan_ready_stuck || $urandom_range(0, 2) == 0)
               rx = 8'($urandom_range(0, 254));
            else
               rx = BYTE_IDLE;
         end
         SEQ_RESPONSE: begin
            if (sb.command_index == CMD_STOP)
               rx = ($urandom_range(0, 2) == 0) ? (rx | R1_ERROR_BIT) : (rx & ~R1_ERROR_BIT);
            else if (sb.command_index == plan_resp_stuck || $urandom_range(0, 2) == 0)
               rx = rx | R1_ERROR_BIT;
            else if (sb.command_index == plan_resp_reject)
               rx = 8'($urandom_range(1, 127));
            else
               rx = R1_READY;
         end
         SEQ_TOKEN: begin
            if ((plan_token_from >= 0 && blocks_done >= plan_token_from) ||
                $urandom_range(0, 2) == 0) begin
               rx = 8'($urandom_range(0, 254));
               if (rx == TOKEN_START) rx = BYTE_IDLE;
            end else
               rx = TOKEN_START;
         end
         default: ;
      endcase
      return rx;
   endfunction

   function automatic logic [SECTOR_W-1:0] random_sector();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return SECTOR_W'($urandom);
      endcase
   endfunction

   // Mostly one or two blocks; the long counts end early through a fault.
   function automatic logic [COUNT_W-1:0] random_count();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return 8'd1;
      if (pick < 7) return 8'd2;
      if (pick == 7) return 8'd0;
      if (pick == 8) return 8'd255;
      return COUNT_W'($urandom);
   endfunction

   // Run one read to its final deselect; now and then restart it midway.
   task automatic run_transfer(input logic [SECTOR_W-1:0] sector,
                               input logic [COUNT_W-1:0] count, input bit clean);
      logic [SECTOR_W-1:0] next_sector;
      logic [COUNT_W-1:0]  next_count;
      choose_plan(count, clean);
      send_start(sector, count);
      transfer_items++;
      while (sb.phase != SEQ_IDLE) begin
         if (!clean && $urandom_range(0, 249) == 0) begin
            next_sector = random_sector();
            next_count  = random_count();
            choose_plan(next_count, 1'b0);
            send_start(next_sector, next_count);
         end else
            send_card_byte(pick_card_byte());
         transfer_items++;
      end
   endtask

   // Run reads until the running item count reaches the target; at least one.
   task automatic run_random_phase(input int target);
      do begin
         // stray bytes while idle are ignored by the sequencer
         repeat ($urandom_range(0, 2)) send_card_byte(8'($urandom));
         run_transfer(random_sector(), random_count(), 1'b0);
      end while (transfer_items < target);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb                  = new();
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.func        = FUNC_BYTE;
      req_bus.sector      = '0;
      req_bus.block_count = '0;
      req_bus.rx_byte     = '0;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_READY_POLL_LIMIT;
      csr_write_data      = '0;
      burst_left          = 0;
      transfer_items      = 0;
      hold_request        = 1'b0;
      hold_done           = 1'b0;
      plan_blocks         = 1;
      plan_ready_stuck    = CMD_NONE;
      plan_resp_reject    = CMD_NONE;
      plan_resp_stuck     = CMD_NONE;
      plan_token_from     = -1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: one-poll limits so every failure is a single byte away.
      program_registers(24'd1, 16'd1, 8'd1, 8'h00);
      send_card_byte(8'h00);                 // bytes while idle
      send_card_byte(8'hFF);
      send_start('1, 8'd1);                  // CMD17 at the top sector
      send_card_byte(8'hAA);
      send_card_byte(8'h00);                 // card not ready on the first poll
      send_card_byte(8'h55);
      send_start('0, 8'd0);                  // count 0 reads 256 blocks, CMD18
      send_card_byte(8'h12);
      send_card_byte(BYTE_IDLE);             // ready at once
      send_card_byte(8'h00);                 // six command bytes go out
      send_card_byte(8'hFF);
      send_card_byte(8'h5A);
      send_card_byte(8'hA5);
      send_card_byte(8'h0F);
      send_card_byte(8'hF0);
      send_card_byte(8'h80);                 // R1 keeps bit 7 set: rejected
      send_start(23'h2AAAAA, 8'd255);
      send_card_byte(8'h01);
      send_start(23'h555555, 8'd1);          // start while busy abandons it
      send_card_byte(8'h00);
      send_card_byte(8'h7F);
      send_card_byte(8'h00);
      wait_for_drain();

      // Highest limits: one clean single-block read, then random traffic.
      program_registers(24'hFFFFFF, 16'hFFFF, 8'd255, 8'hFF);
      run_transfer(random_sector(), 8'd1, 1'b1);
      run_random_phase(650);
      wait_for_drain();

      // Small limits; hold rsp off once so req backs up.
      program_registers(24'd4, 16'd6, 8'd3, 8'h95);
      hold_request = 1'b1;
      run_random_phase(800);
      wait_for_drain();

      // Zero limits act as a single poll.
      program_registers(24'd0, 16'd0, 8'd0, 8'($urandom));
      run_random_phase(950);
      wait_for_drain();

      program_registers(24'($urandom_range(1, 8)), 16'($urandom_range(1, 12)),
                        8'($urandom_range(1, 8)), 8'($urandom));
      run_random_phase(1050);
      wait_for_drain();

      program_registers(24'd20, 16'd40, 8'd32, 8'h01);
      run_random_phase(1200);

      req_bus.valid = 1'b0;
      wait_for_drain();

      if (sb.expected_beats.size() != 0)
         sb.report_mismatch($sformatf("%0d predicted beats never came out",
                                      sb.expected_beats.size()));
      $display("run: %0d reads started, %0d rsp beats checked, %0d sector bytes delivered",
               sb.transfers, sb.checked, sb.data_beats);
      $display("endings: ok %0d, not ready %0d, rejected %0d, token timeout %0d; %0d mismatches",
               sb.endings[STATUS_OK], sb.endings[STATUS_NOT_READY],
               sb.endings[STATUS_REJECTED], sb.endings[STATUS_TIMEOUT], sb.mismatches);
      if (sb.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
